// ===== src/bdsocd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsocd_pkg
// Shared types and constants for the button debounce block with opposing
// d-pad hold.
// ----------------------------------------------------------------------------
package bdsocd_pkg;

  // Widths fixed by the pin and result fields.
  localparam int unsigned PinW   = 17;
  localparam int unsigned LedW   = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 8;

  // Saturation value of a press counter.
  localparam logic [CountW-1:0] CountMax = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] ThresholdReset = 8'd3;
  localparam logic              ActiveLevelReset = 1'b0;

  // Bit positions of the d-pad within the button vector.
  localparam int unsigned BitUp    = 4;
  localparam int unsigned BitDown  = 5;
  localparam int unsigned BitLeft  = 6;
  localparam int unsigned BitRight = 7;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRESS_THRESHOLD = 8'd0,
    CFG_ACTIVE_LEVEL    = 8'd1
  } cfg_idx_e;

  // One result item.
  typedef struct packed {
    logic [PinW-1:0] button_vector;
    logic [LedW-1:0] face_leds;
  } result_t;

  // Handshake control handed to the merge stage.
  typedef struct packed {
    logic accept;
    logic out_stall;
  } merge_ctrl_t;

endpackage

// ===== src/bdsocd_lane.sv =====
// ----------------------------------------------------------------------------
// bdsocd_lane
// Debounce counter for one button: counts consecutive active samples,
// saturates at the top, and flags the button as pressed at the threshold.
// ----------------------------------------------------------------------------
module bdsocd_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              active_i,
  input  logic [bdsocd_pkg::CountW-1:0]     threshold_i,
  output logic                              pressed_o
);

  logic [bdsocd_pkg::CountW-1:0] count_q;
  logic [bdsocd_pkg::CountW-1:0] count_d;

  // Next count: clear on an inactive sample, otherwise count up to saturation.
  always_comb begin
    if (!active_i) begin
      count_d = '0;
    end else if (count_q == bdsocd_pkg::CountMax) begin
      count_d = count_q;
    end else begin
      count_d = count_q + 1'b1;
    end
  end

  // The pressed flag reflects the count after this sample.
  assign pressed_o = (count_d >= threshold_i);

  // Count register advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== src/bdsocd_merge.sv =====
// ----------------------------------------------------------------------------
// bdsocd_merge
// Combines the lane flags into one result item, applies the opposing d-pad
// hold, and keeps results in an output register with a skid stage.
// ----------------------------------------------------------------------------
module bdsocd_merge #(
  parameter int unsigned ButtonCount = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bdsocd_pkg::merge_ctrl_t     ctrl_i,
  input  logic [ButtonCount-1:0]      pressed_i,
  output logic                        skid_full_o,
  output logic                        out_valid_o,
  output bdsocd_pkg::result_t         result_o
);

  // Buttons that have a place in the result vector.
  localparam int unsigned CopyW =
    (ButtonCount < bdsocd_pkg::PinW) ? ButtonCount : bdsocd_pkg::PinW;

  logic [3:0]          held_q;
  logic [3:0]          held_d;
  bdsocd_pkg::result_t res_new;
  logic                out_valid_q;
  bdsocd_pkg::result_t out_q;
  logic                skid_valid_q;
  bdsocd_pkg::result_t skid_q;
  logic                out_take;

  // Opposing-pair hold: an axis with both sides pressed keeps its last output.
  always_comb begin
    held_d = held_q;
    if (!(pressed_i[bdsocd_pkg::BitUp] && pressed_i[bdsocd_pkg::BitDown])) begin
      held_d[0] = pressed_i[bdsocd_pkg::BitUp];
      held_d[1] = pressed_i[bdsocd_pkg::BitDown];
    end
    if (!(pressed_i[bdsocd_pkg::BitLeft] && pressed_i[bdsocd_pkg::BitRight])) begin
      held_d[2] = pressed_i[bdsocd_pkg::BitLeft];
      held_d[3] = pressed_i[bdsocd_pkg::BitRight];
    end
  end

  // Build the result item; bits beyond the button count read as zero.
  always_comb begin
    res_new = '0;
    res_new.button_vector[CopyW-1:0] = pressed_i[CopyW-1:0];
    res_new.button_vector[bdsocd_pkg::BitRight:bdsocd_pkg::BitUp] = held_d;
    res_new.face_leds = pressed_i[bdsocd_pkg::LedW-1:0];
  end

  // D-pad hold state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctrl_i.accept) begin
      held_q <= held_d;
    end
  end

  assign out_take = out_valid_q && !ctrl_i.out_stall;

  // Output register and skid stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= ctrl_i.accept;
      end
    end else if (ctrl_i.accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers follow the same moves as their valid flags.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (ctrl_i.accept) begin
        out_q <= res_new;
      end
    end else if (ctrl_i.accept) begin
      skid_q <= res_new;
    end
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

// ===== src/button_debounce_socd.sv =====
// ----------------------------------------------------------------------------
// button_debounce_socd
// Counter debounce of a row of push buttons with opposing d-pad hold.
// ----------------------------------------------------------------------------
// Each item is one sampling tick carrying the raw level of every button pin.
// One counter lane per button counts consecutive samples at the active level,
// clears on any other sample and saturates at 255; a button is pressed once
// its count reaches press_threshold (register 0). active_level (register 1)
// picks the pin level that means pressed. If both sides of a d-pad axis are
// pressed, that axis repeats its previous output. Every item yields exactly
// one result item, shown in the cycle after it is accepted when the output
// register is free. All lanes update in the same cycle, so an item can be
// accepted every clock. While a result waits, a one-entry skid stage behind
// the output register takes one more item, and the input stalls only while
// that stage is full. Configuration writes are always ready and are expected
// only while idle.
// ----------------------------------------------------------------------------
module button_debounce_socd #(
  parameter int unsigned ButtonCount = 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdsocd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bdsocd_pkg::CfgDataW-1:0]     cfg_data_i,
  // Input item channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bdsocd_pkg::PinW-1:0]         pin_levels_i,
  // Result item channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bdsocd_pkg::PinW-1:0]         button_vector_o,
  output logic [bdsocd_pkg::LedW-1:0]         face_leds_o
);

  logic [bdsocd_pkg::CountW-1:0] threshold_q;
  logic                          active_level_q;
  logic                          in_accept;
  logic                          skid_full;
  logic [ButtonCount-1:0]        pressed;
  bdsocd_pkg::merge_ctrl_t       merge_ctrl;
  bdsocd_pkg::result_t           result;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= bdsocd_pkg::ThresholdReset;
      active_level_q <= bdsocd_pkg::ActiveLevelReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bdsocd_pkg::CFG_PRESS_THRESHOLD: threshold_q <= cfg_data_i;
        bdsocd_pkg::CFG_ACTIVE_LEVEL:    active_level_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake: stall only while the skid stage holds a result.
  assign in_stall_o = skid_full;
  assign in_accept  = in_valid_i && !skid_full;

  // One debounce lane per button; lanes past the pin field see a pin held low.
  for (genvar g = 0; g < ButtonCount; g++) begin : g_lane
    logic active;
    if (g < bdsocd_pkg::PinW) begin : g_pin
      assign active = (pin_levels_i[g] == active_level_q);
    end else begin : g_nopin
      assign active = (active_level_q == 1'b0);
    end

    bdsocd_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (in_accept),
      .active_i    (active),
      .threshold_i (threshold_q),
      .pressed_o   (pressed[g])
    );
  end

  // Merge the lane flags into the result item.
  assign merge_ctrl.accept    = in_accept;
  assign merge_ctrl.out_stall = out_stall_i;

  bdsocd_merge #(
    .ButtonCount (ButtonCount)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (merge_ctrl),
    .pressed_i   (pressed),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign button_vector_o = result.button_vector;
  assign face_leds_o     = result.face_leds;

  // The skid stage only fills behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid stage full while output register is empty");

  // An item accepted into an empty output register is shown next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> out_valid_o)
    else $error("accepted item did not reach the output register");

  // The hold never lets both sides of the vertical axis show together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(button_vector_o[bdsocd_pkg::BitUp] &&
                      button_vector_o[bdsocd_pkg::BitDown]))
    else $error("up and down both reported");

  // The hold never lets both sides of the horizontal axis show together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(button_vector_o[bdsocd_pkg::BitLeft] &&
                      button_vector_o[bdsocd_pkg::BitRight]))
    else $error("left and right both reported");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the button debounce block with d-pad hold.
// ----------------------------------------------------------------------------
// A short directed table covers reset behavior, both d-pad axes pressed at
// once, threshold extremes, a change of active level and a write to an
// unused register index. Random phases follow under several register
// settings; most pin samples hold each button for long runs so that counters
// reach the threshold and saturate. Both channels pause at random. Every
// result item is checked against a local predictor or a typed-in value.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 100;
  localparam logic [bdsocd_pkg::CfgIdxW-1:0] CfgIdxSpare = 8'hFF;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_SAMPLE_KNOWN,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    logic [bdsocd_pkg::CfgIdxW-1:0]   reg_idx;
    logic [bdsocd_pkg::CfgDataW-1:0]  reg_data;
    logic [bdsocd_pkg::PinW-1:0]      pins;
    bdsocd_pkg::result_t              expected;
  } stim_row_t;

  typedef struct packed {
    logic                             random_cfg;
    logic [bdsocd_pkg::CfgDataW-1:0]  threshold;
    logic [bdsocd_pkg::CfgDataW-1:0]  level;
    logic [15:0]                      samples;
    logic [15:0]                      flip_odds;
    logic                             no_idle;
  } phase_t;

  // Directed rows: reset state, opposing presses, extremes of both registers.
  localparam int unsigned DirRows = 24;
  localparam stim_row_t DirectedTab [DirRows] = '{
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h1FFFF, {17'h00000, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h00000, {17'h1FF0F, 4'hF}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h000A0, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h00050, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h15555, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h0AAAA, {17'h00000, 4'h0}},
    '{ROW_WRITE, bdsocd_pkg::CFG_PRESS_THRESHOLD, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h1FFFF, {17'h00000, 4'h0}},
    '{ROW_WRITE, bdsocd_pkg::CFG_ACTIVE_LEVEL,    8'h01, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_WRITE, bdsocd_pkg::CFG_PRESS_THRESHOLD, 8'h01, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h1FFFF, {17'h00000, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h00010, {17'h00010, 4'h0}},
    '{ROW_SAMPLE_KNOWN, 8'h00, 8'h00, 17'h0000F, {17'h0000F, 4'hF}},
    '{ROW_WRITE, bdsocd_pkg::CFG_PRESS_THRESHOLD, 8'hFF, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h1FFFF, {17'h00000, 4'h0}},
    '{ROW_WRITE, bdsocd_pkg::CFG_ACTIVE_LEVEL,    8'hFE, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_WRITE, CfgIdxSpare,                     8'h01, 17'h00000, {17'h00000, 4'h0}},
    '{ROW_SAMPLE,       8'h00, 8'h00, 17'h00000, {17'h00000, 4'h0}}
  };

  // Random phases: register setting, length, button flip odds, idle mode.
  localparam int unsigned NumPhases = 6;
  localparam phase_t PhaseTab [NumPhases] = '{
    '{1'b0, 8'd3,   8'h00, 16'd80,  16'd8,   1'b0},
    '{1'b0, 8'd1,   8'h01, 16'd80,  16'd4,   1'b1},
    '{1'b0, 8'd0,   8'h00, 16'd40,  16'd4,   1'b0},
    '{1'b0, 8'd255, 8'h01, 16'd300, 16'd512, 1'b0},
    '{1'b1, 8'd0,   8'h00, 16'd100, 16'd16,  1'b0},
    '{1'b1, 8'd0,   8'h00, 16'd100, 16'd32,  1'b1}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [bdsocd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [bdsocd_pkg::CfgDataW-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [bdsocd_pkg::PinW-1:0]     pin_levels_i;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [bdsocd_pkg::PinW-1:0]     button_vector_o;
  logic [bdsocd_pkg::LedW-1:0]     face_leds_o;

  // Expected value that travels with a directed item, when it is typed in.
  logic                            sample_known;
  bdsocd_pkg::result_t             sample_expected;

  // Predictor state and register copies.
  logic [bdsocd_pkg::CountW-1:0]   run_len [bdsocd_pkg::PinW];
  logic [3:0]                      dpad_last;
  logic [bdsocd_pkg::CountW-1:0]   cur_threshold;
  logic                            cur_level;

  bdsocd_pkg::result_t             debounced_q [$];
  int unsigned                     samples_taken;
  int unsigned                     results_checked;
  int unsigned                     mismatch_cnt;
  int unsigned                     cycle_cnt;
  bit                              tx_quiet;
  bit                              rx_quiet;

  button_debounce_socd #(
    .ButtonCount(bdsocd_pkg::PinW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pin_levels_i   (pin_levels_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_vector_o(button_vector_o),
    .face_leds_o    (face_leds_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One sampling tick of the debouncer: advances the counters and the d-pad
  // hold, and returns the result item that the tick produces.
  function automatic bdsocd_pkg::result_t debounce_tick(
      input logic [bdsocd_pkg::PinW-1:0] pins);
    int                          b;
    logic [bdsocd_pkg::PinW-1:0] pressed;
    logic [3:0]                  dpad;
    bdsocd_pkg::result_t         res;
    pressed = '0;
    for (b = 0; b < bdsocd_pkg::PinW; b++) begin
      if (pins[b] == cur_level) begin
        if (run_len[b] != bdsocd_pkg::CountMax) begin
          run_len[b] = run_len[b] + 1'b1;
        end
      end else begin
        run_len[b] = '0;
      end
      pressed[b] = (run_len[b] >= cur_threshold);
    end
    dpad = dpad_last;
    // An axis with both sides pressed keeps what it showed last tick.
    if (!(pressed[bdsocd_pkg::BitUp] && pressed[bdsocd_pkg::BitDown])) begin
      dpad[0] = pressed[bdsocd_pkg::BitUp];
      dpad[1] = pressed[bdsocd_pkg::BitDown];
    end
    if (!(pressed[bdsocd_pkg::BitLeft] && pressed[bdsocd_pkg::BitRight])) begin
      dpad[2] = pressed[bdsocd_pkg::BitLeft];
      dpad[3] = pressed[bdsocd_pkg::BitRight];
    end
    dpad_last = dpad;
    res.button_vector = pressed;
    res.button_vector[bdsocd_pkg::BitRight:bdsocd_pkg::BitUp] = dpad;
    res.face_leds = pressed[bdsocd_pkg::LedW-1:0];
    return res;
  endfunction

  // Monitor: register writes, accepted samples and accepted result items.
  always @(posedge clk_i) begin : monitor
    bdsocd_pkg::result_t exp_res;
    int                  b;
    if (!rst_ni) begin
      for (b = 0; b < bdsocd_pkg::PinW; b++) begin
        run_len[b] = '0;
      end
      dpad_last = '0;
      cur_threshold = bdsocd_pkg::ThresholdReset;
      cur_level = bdsocd_pkg::ActiveLevelReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bdsocd_pkg::CFG_PRESS_THRESHOLD: cur_threshold = cfg_data_i;
          bdsocd_pkg::CFG_ACTIVE_LEVEL:    cur_level = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        exp_res = debounce_tick(pin_levels_i);
        if (sample_known) begin
          exp_res = sample_expected;
        end
        debounced_q.push_back(exp_res);
        samples_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (debounced_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("%0t ns: result with none expected, button_vector %05h face_leds %01h",
                     $time, button_vector_o, face_leds_o);
          end
        end else begin
          exp_res = debounced_q.pop_front();
          if (button_vector_o !== exp_res.button_vector) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
              $display("%0t ns: button_vector expected %05h actual %05h",
                       $time, exp_res.button_vector, button_vector_o);
            end
          end
          if (face_leds_o !== exp_res.face_leds) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
              $display("%0t ns: face_leds expected %01h actual %01h",
                       $time, exp_res.face_leds, face_leds_o);
            end
          end
        end
      end
    end
  end

  // Receiver pacing: runs of free cycles and stalls, mostly short stalls.
  always @(posedge clk_i) begin : rx_pace
    int unsigned stall_left;
    int unsigned free_left;
    int unsigned pick;
    if (rx_quiet) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (free_left != 0) begin
        free_left--;
      end else begin
        free_left = $urandom_range(0, 12);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          stall_left = $urandom_range(1, 2);
        end else if (pick < 95) begin
          stall_left = $urandom_range(3, 8);
        end else begin
          stall_left = $urandom_range(20, 60);
        end
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t ns: run exceeded %0d cycles with %0d results pending",
               $time, CycleLimit, debounced_q.size());
      $display("button_debounce_socd verification failed");
      $finish;
    end
  end

  // Lower the item valid and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (debounced_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(input logic [bdsocd_pkg::CfgIdxW-1:0] idx,
                           input logic [bdsocd_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random pause of the sender before the next item.
  task automatic sender_gap();
    int unsigned pick;
    int unsigned gap;
    gap = 0;
    if (!tx_quiet) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) begin
        gap = $urandom_range(10, 40);
      end else if (pick >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Offer one pin sample and hold it until it is taken.
  task automatic send_sample(input logic [bdsocd_pkg::PinW-1:0] pins, input logic known,
                             input bdsocd_pkg::result_t expected);
    in_valid_i      <= 1'b1;
    pin_levels_i    <= pins;
    sample_known    <= known;
    sample_expected <= expected;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  // Stimulus: directed table, then random phases under several settings.
  initial begin : stimulus
    int unsigned                     r;
    int unsigned                     p;
    int unsigned                     k;
    int unsigned                     b;
    stim_row_t                       row;
    phase_t                          ph;
    logic [bdsocd_pkg::CfgDataW-1:0] thr_set;
    logic [bdsocd_pkg::CfgDataW-1:0] lvl_set;
    logic [bdsocd_pkg::PinW-1:0]     pins_now;
    logic [31:0]                     rnd_word;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    pin_levels_i    = '0;
    sample_known    = 1'b0;
    sample_expected = '0;
    samples_taken   = 0;
    results_checked = 0;
    mismatch_cnt    = 0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows.
    for (r = 0; r < DirRows; r++) begin
      row = DirectedTab[r];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        sender_gap();
        send_sample(row.pins, row.kind == ROW_SAMPLE_KNOWN, row.expected);
      end
    end

    // Random phases. Buttons mostly hold their level for long runs, with
    // some fully random samples mixed in as bounce noise; the long-hold
    // phase leaves the noise out so that counters run up to saturation.
    rnd_word = $urandom;
    pins_now = rnd_word[bdsocd_pkg::PinW-1:0];
    for (p = 0; p < NumPhases; p++) begin
      ph = PhaseTab[p];
      drain_results();
      if (ph.random_cfg) begin
        rnd_word = $urandom_range(1, 24);
        thr_set  = rnd_word[bdsocd_pkg::CfgDataW-1:0];
        rnd_word = $urandom_range(0, 255);
        lvl_set  = rnd_word[bdsocd_pkg::CfgDataW-1:0];
      end else begin
        thr_set = ph.threshold;
        lvl_set = ph.level;
      end
      write_reg(bdsocd_pkg::CFG_PRESS_THRESHOLD, thr_set);
      write_reg(bdsocd_pkg::CFG_ACTIVE_LEVEL, lvl_set);
      tx_quiet = ph.no_idle;
      rx_quiet = ph.no_idle;
      for (k = 0; k < ph.samples; k++) begin
        // Now and then the sender waits for every result to come back.
        if (k == ph.samples / 2 || $urandom_range(0, 149) == 0) begin
          drain_results();
        end
        if (ph.flip_odds < 16'd64 && $urandom_range(0, 9) == 0) begin
          rnd_word = $urandom;
          pins_now = rnd_word[bdsocd_pkg::PinW-1:0];
        end else begin
          for (b = 0; b < bdsocd_pkg::PinW; b++) begin
            if ($urandom_range(0, ph.flip_odds - 1) == 0) begin
              pins_now[b] = ~pins_now[b];
            end
          end
        end
        sender_gap();
        send_sample(pins_now, 1'b0, '0);
      end
    end

    // Let the last results come out, then watch for stray ones.
    drain_results();
    repeat (10) @(posedge clk_i);
    mismatch_cnt += debounced_q.size();

    $display("Run took %0d pin samples and checked %0d result items, %0d directed rows",
             samples_taken, results_checked, DirRows);
    $display("and %0d random phases, thresholds 0, 1 and 255 and both active levels.",
             NumPhases);
    if (mismatch_cnt == 0) begin
      $display("button_debounce_socd verification clean");
    end else begin
      $display("button_debounce_socd verification failed");
    end
    $finish;
  end

endmodule
